// ----- design/hte_pkg.sv -----
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants for the header/tail frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package hte_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_HEADER_PATTERN = 2'd0;
    localparam logic [1:0] REG_HEADER_LENGTH  = 2'd1;
    localparam logic [1:0] REG_TAIL_BYTE      = 2'd2;
    localparam logic [1:0] REG_MAX_FRAME_LEN  = 2'd3;

    localparam logic [47:0] RST_HEADER_PATTERN = 48'd46458108790349;
    localparam logic [2:0]  RST_HEADER_LENGTH  = 3'd6;
    localparam logic [7:0]  RST_TAIL_BYTE      = 8'd35;
    localparam logic [8:0]  RST_MAX_FRAME_LEN  = 9'd256;

    localparam logic [8:0]  MIN_FRAME_LEN      = 9'd8;

    typedef struct packed {
        logic [47:0] header_pattern;
        logic [2:0]  header_length;
        logic [7:0]  tail_byte;
        logic [8:0]  max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic       end_status;
    } res_t;

endpackage

`default_nettype wire

// ----- design/hte_regs.sv -----
// ----------------------------------------------------------------------------
// hte_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_regs
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hte_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hte_pkg::DATA_W-1:0]   pwdata,
    output logic      [hte_pkg::DATA_W-1:0]   prdata,
    output hte_pkg::cfg_t                     cfg
);

    hte_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:3];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_pattern <= hte_pkg::RST_HEADER_PATTERN;
            cfg_reg.header_length  <= hte_pkg::RST_HEADER_LENGTH;
            cfg_reg.tail_byte      <= hte_pkg::RST_TAIL_BYTE;
            cfg_reg.max_frame_len  <= hte_pkg::RST_MAX_FRAME_LEN;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                hte_pkg::REG_HEADER_PATTERN: cfg_reg.header_pattern <= pwdata[47:0];
                hte_pkg::REG_HEADER_LENGTH:  cfg_reg.header_length  <= pwdata[2:0];
                hte_pkg::REG_TAIL_BYTE:      cfg_reg.tail_byte      <= pwdata[7:0];
                hte_pkg::REG_MAX_FRAME_LEN:  cfg_reg.max_frame_len  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            hte_pkg::REG_HEADER_PATTERN: prdata = {16'd0, cfg_reg.header_pattern};
            hte_pkg::REG_HEADER_LENGTH:  prdata = {61'd0, cfg_reg.header_length};
            hte_pkg::REG_TAIL_BYTE:      prdata = {56'd0, cfg_reg.tail_byte};
            hte_pkg::REG_MAX_FRAME_LEN:  prdata = {55'd0, cfg_reg.max_frame_len};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/hte_core.sv -----
// ----------------------------------------------------------------------------
// hte_core
// Frame state: header match, payload count and chunk discard, one byte a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_core
#(
    parameter int MAX_FRAME_LIMIT  = 256,
    parameter int HEADER_MAX_BYTES = 6
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hte_pkg::cfg_t cfg,
    input  wire logic          in_accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               res_valid,
    output hte_pkg::res_t      res
);

    localparam int CW = $clog2(MAX_FRAME_LIMIT + 1);
    localparam int LW = (CW > 9) ? CW : 9;
    localparam int IW = (HEADER_MAX_BYTES > 1) ? $clog2(HEADER_MAX_BYTES) : 1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [IW-1:0]   hidx_reg, hidx_next;
    logic [CW-1:0]   fcnt_reg, fcnt_next;

    logic [63:0]     pat_ext;
    logic [LW-1:0]   max_ext;
    logic [LW-1:0]   lim;
    logic [LW-1:0]   n;
    logic [3:0]      hlen;
    logic [3:0]      idx;
    logic [3:0]      idx_inc;
    logic [7:0]      hbyte;

    assign pat_ext = {16'd0, cfg.header_pattern};
    assign max_ext = LW'(cfg.max_frame_len);
    assign n       = LW'(fcnt_reg) + LW'(1);

    always_comb
    begin
        if (max_ext < LW'(hte_pkg::MIN_FRAME_LEN))
            lim = LW'(hte_pkg::MIN_FRAME_LEN);
        else if (max_ext > LW'(MAX_FRAME_LIMIT))
            lim = LW'(MAX_FRAME_LIMIT);
        else
            lim = max_ext;

        if (cfg.header_length == 3'd0)
            hlen = 4'd1;
        else if ({1'b0, cfg.header_length} > 4'(HEADER_MAX_BYTES))
            hlen = 4'(HEADER_MAX_BYTES);
        else
            hlen = {1'b0, cfg.header_length};

        idx = 4'(hidx_reg);
        if (idx >= 4'(HEADER_MAX_BYTES))
            idx = 4'd0;
        idx_inc = idx + 4'd1;

        hbyte = 8'd0;
        for (int k = 0; k < HEADER_MAX_BYTES; k++)
        begin
            if (idx == 4'(k))
                hbyte = pat_ext[8*(HEADER_MAX_BYTES-1-k) +: 8];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        fcnt_next  = fcnt_reg;
        res_valid  = 1'b0;
        res        = '0;
        case (phase_reg)
            PH_PAYLOAD:
            begin
                if (in_byte == cfg.tail_byte && n < lim)
                begin
                    phase_next   = PH_HEADER;
                    hidx_next    = '0;
                    fcnt_next    = '0;
                    res_valid    = 1'b1;
                    res.is_end   = 1'b1;
                end
                else if (n >= lim)
                begin
                    phase_next     = in_last ? PH_HEADER : PH_DISCARD;
                    hidx_next      = '0;
                    fcnt_next      = '0;
                    res_valid      = 1'b1;
                    res.is_end     = 1'b1;
                    res.end_status = 1'b1;
                end
                else
                begin
                    fcnt_next    = CW'(n);
                    res_valid    = 1'b1;
                    res.out_byte = in_byte;
                end
            end
            PH_DISCARD:
            begin
                if (in_last)
                begin
                    phase_next = PH_HEADER;
                    hidx_next  = '0;
                    fcnt_next  = '0;
                end
            end
            default:
            begin
                if (in_byte == hbyte)
                begin
                    if (idx_inc >= hlen)
                    begin
                        phase_next = PH_PAYLOAD;
                        hidx_next  = '0;
                        fcnt_next  = CW'(hlen);
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        hidx_next  = IW'(idx_inc);
                        fcnt_next  = '0;
                    end
                end
                else
                begin
                    phase_next = in_last ? PH_HEADER : PH_DISCARD;
                    hidx_next  = '0;
                    fcnt_next  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            fcnt_reg  <= '0;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> fcnt_reg != '0)
        else $error("payload phase with empty frame count");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_PAYLOAD |-> fcnt_reg == '0)
        else $error("frame count set outside payload phase");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && res_valid && res.is_end |=> phase_reg != PH_PAYLOAD && hidx_reg == '0)
        else $error("frame end did not leave payload phase");

endmodule

`default_nettype wire

// ----- design/hte_obuf.sv -----
// ----------------------------------------------------------------------------
// hte_obuf
// Output register between the frame logic and the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hte_obuf
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_accept,
    input  wire logic          res_valid,
    input  wire hte_pkg::res_t res,
    output logic               in_ready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    logic          valid_reg;
    hte_pkg::res_t data_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.out_byte;
    assign m_tlast  = data_reg.is_end;
    assign m_tuser  = data_reg.end_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_accept && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
            data_reg <= res;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

// ----- design/header_tail_frame_extractor.sv -----
// ----------------------------------------------------------------------------
// header_tail_frame_extractor
// Delimiter-framed byte deframer: header match, cut-through payload, tail end.
//
//   channel  dir  signals                          content
//   s_*      in   s_tvalid s_tready s_tdata s_tlast  received byte, chunk end
//   m_*      out  m_tvalid m_tready m_tdata m_tlast  payload byte, frame end
//                 m_tuser                          end status (1 = too long)
//   apb      in   psel penable pwrite paddr pwdata   config at 8*index
//
// One byte per cycle while the output is not stalled; results pass through the output register.
// Frame state updates in the beat a byte is accepted; results sit in the
// output register. A stalled output blocks s_tready only while the output
// register is full. Reset clears frame state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module header_tail_frame_extractor
#(
    parameter int MAX_FRAME_LIMIT  = 256,
    parameter int HEADER_MAX_BYTES = 6
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  wire logic                         s_tlast,   // chunk_end
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [7:0]                   m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // is_end
    output logic                              m_tuser,   // [0] end_status
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hte_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hte_pkg::DATA_W-1:0]   pwdata,
    output logic      [hte_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    hte_pkg::cfg_t cfg;
    hte_pkg::res_t res;
    logic          res_valid;
    logic          in_accept;

    assign pready    = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    hte_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    hte_core #(
        .MAX_FRAME_LIMIT  (MAX_FRAME_LIMIT),
        .HEADER_MAX_BYTES (HEADER_MAX_BYTES)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    hte_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
